[hw/rtl/led_channel_command_parser_top_defines.svh]
// ----------------------------------------------------------------------------
// LED channel command parser assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef LED_CHANNEL_COMMAND_PARSER_TOP_DEFINES_SVH
`define LED_CHANNEL_COMMAND_PARSER_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LCCP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LCCP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/lccp_pkg.sv]
// ----------------------------------------------------------------------------
// LED channel command parser package
// Sizes, command and reply codes, and the controller/datapath interface types.
// ----------------------------------------------------------------------------
package lccp_pkg;

  localparam int CHANNELS   = 8;
  localparam int VALUE_BITS = 5;
  localparam int BYTE_W     = 8;
  localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef logic [CH_W-1:0]       chan_t;
  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [BYTE_W-1:0]     byte_t;

  localparam byte_t ACK_BYTE = 8'hC0;

  // Header command field, bits 7..5.
  localparam logic [2:0] CMD_GET      = 3'd0;
  localparam logic [2:0] CMD_SET      = 3'd1;
  localparam logic [2:0] CMD_GET_BULK = 3'd2;
  localparam logic [2:0] CMD_SET_BULK = 3'd3;
  localparam logic [2:0] CMD_READ     = 3'd4;
  localparam logic [2:0] CMD_WRITE    = 3'd5;

  // Source of the reply byte.
  localparam logic [1:0] OUT_ROW = 2'd0;
  localparam logic [1:0] OUT_ACK = 2'd1;
  localparam logic [1:0] OUT_ERR = 2'd2;

  typedef struct packed {
    logic       hdr_load;
    logic       rd_hdr;
    logic       row_write;
    logic       ch_inc;
    logic       rem_load;
    logic       rem_dec;
    logic       out_load;
    logic [1:0] out_sel;
    logic       out_last;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       len_zero;
    logic       len_one;
    logic       rem_zero;
    logic       rem_one;
  } dp_status_t;

  // Header channel field taken modulo the channel count, as a small table.
  function automatic chan_t chan_of_header(logic [2:0] field);
    chan_t r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      if (field == 3'(i)) begin
        r = chan_t'(i % CHANNELS);
      end
    end
    return r;
  endfunction

endpackage

[hw/rtl/led_channel_command_parser_top.sv]
// ----------------------------------------------------------------------------
// LED channel command parser
// Serial command byte parser with an eight-channel LED row store.
// ----------------------------------------------------------------------------
// The block takes one received byte per input transfer and returns reply bytes
// through a one-deep output register. A header byte carries the command in
// bits 7..5, the start channel in bits 4..2 and the OR-merge flag in bit 1.
// GET replies with one channel value; SET takes one data byte and acks with
// 0xC0; GET_BULK takes a length and streams that many consecutive channels,
// one reply byte per cycle unless the output stalls, with last_of_run on
// the final one; SET_BULK takes a length and that many data bytes and acks
// after the last. Lengths above eight count as eight and channels wrap
// around. READ and WRITE headers are swallowed, and commands 6 and 7 return
// a single byte with cmd_error set. An input byte is taken whenever the
// output register is free and no bulk read run is in progress: a bulk read
// holds off input for its whole run of up to eight reply bytes, as the
// controller walks the row store one channel per cycle through its single
// read port; output stalls stretch the run. The row store is cleared by reset.
// ----------------------------------------------------------------------------
module led_channel_command_parser_top (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  lccp_pkg::byte_t rx_byte,
  output logic            out_valid,
  input  logic            out_stall,
  output lccp_pkg::byte_t reply_byte,
  output logic            last_of_run,
  output logic            cmd_error
);
  import lccp_pkg::*;

  // Commands flow from the controller to the datapath; decoded header and
  // count status flows back.
  dp_cmd_t    cmd;
  dp_status_t status;

  lccp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  lccp_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .rx_byte     (rx_byte),
    .cmd         (cmd),
    .status      (status),
    .reply_byte  (reply_byte),
    .last_of_run (last_of_run),
    .cmd_error   (cmd_error)
  );

endmodule

[hw/rtl/lccp_datapath.sv]
// ----------------------------------------------------------------------------
// LED channel command parser datapath
// Row store, channel and count registers, and the registered reply payload.
// ----------------------------------------------------------------------------
module lccp_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  lccp_pkg::byte_t      rx_byte,
  input  lccp_pkg::dp_cmd_t    cmd,
  output lccp_pkg::dp_status_t status,
  output lccp_pkg::byte_t      reply_byte,
  output logic                 last_of_run,
  output logic                 cmd_error
);
  import lccp_pkg::*;

  value_t row_store [CHANNELS];
  chan_t  current_channel;
  logic   merge_flag;
  chan_t  bytes_remaining;

  chan_t  hdr_chan;
  chan_t  rd_addr;
  value_t row_rd;
  value_t wr_val;
  chan_t  chan_inc;
  chan_t  len_m1;
  byte_t  reply_next;

  always_comb begin
    hdr_chan = chan_of_header(rx_byte[4:2]);
    rd_addr  = cmd.rd_hdr ? hdr_chan : current_channel;
    row_rd   = row_store[rd_addr];
    wr_val   = rx_byte[VALUE_BITS-1:0] | (merge_flag ? row_rd : '0);
    chan_inc = (current_channel == chan_t'(CHANNELS - 1)) ? '0
                                                          : current_channel + chan_t'(1);
    // Clamped length minus one; only used when the length is not zero.
    len_m1   = (rx_byte >= byte_t'(CHANNELS)) ? chan_t'(CHANNELS - 1)
                                              : chan_t'(rx_byte) - chan_t'(1);
    case (cmd.out_sel)
      OUT_ROW: reply_next = byte_t'(row_rd);
      OUT_ACK: reply_next = ACK_BYTE;
      default: reply_next = '0;
    endcase
  end

  assign status.cmd      = rx_byte[7:5];
  assign status.len_zero = (rx_byte == '0);
  assign status.len_one  = (rx_byte == byte_t'(1));
  assign status.rem_zero = (bytes_remaining == '0);
  assign status.rem_one  = (bytes_remaining == chan_t'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        row_store[i] <= '0;
      end
      current_channel <= '0;
      merge_flag      <= 1'b0;
      bytes_remaining <= '0;
    end else begin
      if (cmd.row_write) begin
        row_store[current_channel] <= wr_val;
      end
      if (cmd.hdr_load) begin
        current_channel <= hdr_chan;
        merge_flag      <= rx_byte[1];
      end else if (cmd.ch_inc) begin
        current_channel <= chan_inc;
      end
      if (cmd.rem_load) begin
        bytes_remaining <= len_m1;
      end else if (cmd.rem_dec) begin
        bytes_remaining <= bytes_remaining - chan_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      reply_byte  <= reply_next;
      last_of_run <= cmd.out_last;
      cmd_error   <= (cmd.out_sel == OUT_ERR);
    end
  end

endmodule

[hw/rtl/lccp_ctrl.sv]
// ----------------------------------------------------------------------------
// LED channel command parser controller
// Byte phase state machine and the reply slot handshake.
// ----------------------------------------------------------------------------
module lccp_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  lccp_pkg::dp_status_t status,
  output lccp_pkg::dp_cmd_t    cmd
);
  import lccp_pkg::*;
  `include "led_channel_command_parser_top_defines.svh"

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_SET_DATA  = 3'd1;
  localparam logic [2:0] ST_GETB_LEN  = 3'd2;
  localparam logic [2:0] ST_SETB_LEN  = 3'd3;
  localparam logic [2:0] ST_SETB_DATA = 3'd4;
  localparam logic [2:0] ST_GETB_RUN  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_valid_next;
  logic       slot_free;
  logic       in_acc;

  // The reply slot can take a new byte when it is empty or being drained.
  assign slot_free = ~out_valid | ~out_stall;
  assign in_stall  = (state == ST_GETB_RUN) | (out_valid & out_stall);
  assign in_acc    = in_valid & ~in_stall;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          cmd.hdr_load = 1'b1;
          unique case (status.cmd) inside
            CMD_GET: begin
              cmd.out_load = 1'b1;
              cmd.rd_hdr   = 1'b1;
              cmd.out_sel  = OUT_ROW;
              cmd.out_last = 1'b1;
            end
            CMD_SET:      state_next = ST_SET_DATA;
            CMD_GET_BULK: state_next = ST_GETB_LEN;
            CMD_SET_BULK: state_next = ST_SETB_LEN;
            CMD_READ, CMD_WRITE: begin
              state_next = ST_IDLE;
            end
            default: begin
              cmd.out_load = 1'b1;
              cmd.out_sel  = OUT_ERR;
              cmd.out_last = 1'b1;
            end
          endcase
        end
      end
      ST_SET_DATA: begin
        if (in_acc) begin
          cmd.row_write = 1'b1;
          cmd.out_load  = 1'b1;
          cmd.out_sel   = OUT_ACK;
          cmd.out_last  = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      ST_GETB_LEN: begin
        if (in_acc) begin
          if (status.len_zero) begin
            state_next = ST_IDLE;
          end else begin
            cmd.out_load = 1'b1;
            cmd.out_sel  = OUT_ROW;
            cmd.out_last = status.len_one;
            cmd.ch_inc   = 1'b1;
            cmd.rem_load = 1'b1;
            state_next   = status.len_one ? ST_IDLE : ST_GETB_RUN;
          end
        end
      end
      ST_GETB_RUN: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = OUT_ROW;
          cmd.out_last = status.rem_one;
          cmd.ch_inc   = 1'b1;
          cmd.rem_dec  = 1'b1;
          if (status.rem_one) begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_SETB_LEN: begin
        if (in_acc) begin
          if (status.len_zero) begin
            cmd.out_load = 1'b1;
            cmd.out_sel  = OUT_ACK;
            cmd.out_last = 1'b1;
            state_next   = ST_IDLE;
          end else begin
            cmd.rem_load = 1'b1;
            state_next   = ST_SETB_DATA;
          end
        end
      end
      ST_SETB_DATA: begin
        if (in_acc) begin
          cmd.row_write = 1'b1;
          cmd.ch_inc    = 1'b1;
          if (status.rem_zero) begin
            cmd.out_load = 1'b1;
            cmd.out_sel  = OUT_ACK;
            cmd.out_last = 1'b1;
            state_next   = ST_IDLE;
          end else begin
            cmd.rem_dec = 1'b1;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign out_valid_next = cmd.out_load | (out_valid & out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  `LCCP_ASSERT_NOW(a_load_into_free_slot, cmd.out_load, slot_free, "reply overwrote a held byte")
  `LCCP_ASSERT_NEXT(a_run_holds_on_stall, (state == ST_GETB_RUN) && !slot_free, (state == ST_GETB_RUN), "bulk run ended while stalled")
  `LCCP_ASSERT_NEXT(a_run_fills_slot, (state == ST_GETB_RUN) && slot_free, out_valid, "bulk run missed a byte")
  `LCCP_ASSERT_NOW(a_error_is_last, cmd.out_load && (cmd.out_sel == OUT_ERR), cmd.out_last && (state == ST_IDLE), "error reply not a lone last byte")

endmodule

[sim/led_channel_command_parser_checker.sv]
// ----------------------------------------------------------------------------
// LED channel command parser checker
// Watches both transfer channels of the parser, keeps its own copy of the
// row store and parse state, and compares every reply byte in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module led_channel_command_parser_checker (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_stall,
  input  lccp_pkg::byte_t rx_byte,
  input  logic            out_valid,
  input  logic            out_stall,
  input  lccp_pkg::byte_t reply_byte,
  input  logic            last_of_run,
  input  logic            cmd_error,
  output int              fail_count,
  output int              expected_count
);
  import lccp_pkg::*;

  typedef enum logic [2:0] {
    WAIT_HEADER,
    WAIT_SET_DATA,
    WAIT_GETB_LEN,
    WAIT_SETB_LEN,
    WAIT_SETB_DATA
  } parse_phase_t;

  typedef struct packed {
    byte_t reply;
    logic  last;
    logic  err;
  } reply_t;

  reply_t       reply_queue[$];
  value_t       rows[CHANNELS];
  parse_phase_t phase;
  chan_t        chan;
  logic         merge;
  logic [3:0]   remaining;

  function automatic chan_t following_channel(chan_t c);
    return (int'(c) + 1 >= CHANNELS) ? chan_t'(0) : chan_t'(int'(c) + 1);
  endfunction

  function automatic int clamped_length(byte_t b);
    return (int'(b) > CHANNELS) ? CHANNELS : int'(b);
  endfunction

  task automatic push_reply(byte_t r, logic l, logic e);
    reply_t item;
    item.reply = r;
    item.last  = l;
    item.err   = e;
    reply_queue.push_back(item);
  endtask

  // Upper data bits beyond the row width are dropped before the write or OR.
  task automatic store_row(chan_t c, byte_t b);
    value_t v;
    v = b[VALUE_BITS-1:0];
    if (merge) begin
      v = v | rows[c];
    end
    rows[c] = v;
  endtask

  task automatic predict_replies(byte_t b);
    int    len;
    chan_t c;
    case (phase)
      WAIT_SET_DATA: begin
        store_row(chan, b);
        phase = WAIT_HEADER;
        push_reply(ACK_BYTE, 1'b1, 1'b0);
      end
      WAIT_GETB_LEN: begin
        len = clamped_length(b);
        c   = chan;
        for (int i = 0; i < len; i++) begin
          push_reply(byte_t'(rows[c]), i == len - 1, 1'b0);
          c = following_channel(c);
        end
        phase = WAIT_HEADER;
      end
      WAIT_SETB_LEN: begin
        len = clamped_length(b);
        if (len == 0) begin
          phase = WAIT_HEADER;
          push_reply(ACK_BYTE, 1'b1, 1'b0);
        end else begin
          remaining = 4'(len);
          phase     = WAIT_SETB_DATA;
        end
      end
      WAIT_SETB_DATA: begin
        store_row(chan, b);
        chan = following_channel(chan);
        if (remaining != 0) begin
          remaining = remaining - 4'd1;
        end
        if (remaining == 0) begin
          phase = WAIT_HEADER;
          push_reply(ACK_BYTE, 1'b1, 1'b0);
        end
      end
      default: begin
        phase = WAIT_HEADER;
        chan  = chan_t'(int'(b[4:2]) % CHANNELS);
        merge = b[1];
        case (b[7:5])
          CMD_GET:      push_reply(byte_t'(rows[chan]), 1'b1, 1'b0);
          CMD_SET:      phase = WAIT_SET_DATA;
          CMD_GET_BULK: phase = WAIT_GETB_LEN;
          CMD_SET_BULK: phase = WAIT_SETB_LEN;
          CMD_READ, CMD_WRITE: ;
          default:      push_reply('0, 1'b1, 1'b1);
        endcase
      end
    endcase
  endtask

  always @(posedge clk) begin : monitor
    reply_t want;
    if (rst) begin
      foreach (rows[i]) rows[i] = '0;
      phase     = WAIT_HEADER;
      chan      = '0;
      merge     = 1'b0;
      remaining = '0;
      reply_queue.delete();
    end else begin
      if (in_valid && !in_stall) begin
        predict_replies(rx_byte);
      end
      if (out_valid && !out_stall) begin
        if (reply_queue.size() == 0) begin
          $error("unexpected reply transfer: reply_byte %0h", reply_byte);
          fail_count++;
        end else begin
          want = reply_queue.pop_front();
          if (reply_byte !== want.reply) begin
            $error("reply_byte: expected %0h, got %0h", want.reply, reply_byte);
            fail_count++;
          end
          if (last_of_run !== want.last) begin
            $error("last_of_run: expected %0b, got %0b", want.last, last_of_run);
            fail_count++;
          end
          if (cmd_error !== want.err) begin
            $error("cmd_error: expected %0b, got %0b", want.err, cmd_error);
            fail_count++;
          end
        end
      end
    end
    expected_count = reply_queue.size();
  end

endmodule

[sim/tb_led_channel_command_parser_top.sv]
// ----------------------------------------------------------------------------
// LED channel command parser testbench
// Drives command byte sequences into the parser with random idle cycles and
// output stalls, and leaves prediction and comparison to the checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_led_channel_command_parser_top;
  import lccp_pkg::*;

  // The package names only the six defined commands; these two must error.
  localparam logic [2:0] CMD_UNKNOWN_A = 3'd6;
  localparam logic [2:0] CMD_UNKNOWN_B = 3'd7;

  localparam int RANDOM_ITEMS = 250;

  logic  clk = 1'b0;
  logic  rst;
  logic  in_valid;
  logic  in_stall;
  byte_t rx_byte;
  logic  out_valid;
  logic  out_stall;
  byte_t reply_byte;
  logic  last_of_run;
  logic  cmd_error;

  int fail_count;
  int expected_count;
  int random_items;

  // While steady is set, neither the sender nor the receiver inserts idle
  // cycles, so back-to-back transfers are exercised as well.
  bit steady;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  led_channel_command_parser_top u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .rx_byte     (rx_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .reply_byte  (reply_byte),
    .last_of_run (last_of_run),
    .cmd_error   (cmd_error)
  );

  led_channel_command_parser_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .reply_byte     (reply_byte),
    .last_of_run    (last_of_run),
    .cmd_error      (cmd_error),
    .fail_count     (fail_count),
    .expected_count (expected_count)
  );

  // A header byte: command in bits 7..5, start channel in 4..2, merge flag
  // in bit 1. Bit 0 is don't-care for the parser and is left at zero here.
  function automatic byte_t header(logic [2:0] cmd, logic [2:0] ch, logic merge);
    return {cmd, ch, merge, 1'b0};
  endfunction

  // One input transfer. Called at a falling edge, returns at the falling edge
  // after the byte was taken. Valid is only lowered when an idle gap is drawn,
  // so a zero gap keeps it high across consecutive transfers without a glitch.
  task automatic send_byte(byte_t b);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // A well-formed command with random content. The command mix leans toward
  // the ones that carry follow-up bytes, since those reach the deeper parse
  // phases. Bulk lengths are mostly in range, sometimes zero and sometimes
  // far too long so that the clamp to the channel count is hit.
  task automatic send_random_command();
    logic [2:0] cmd;
    byte_t      len_byte;
    int         data_count;
    case ($urandom_range(0, 9))
      0, 1:    cmd = CMD_GET;
      2, 3:    cmd = CMD_SET;
      4, 5:    cmd = CMD_GET_BULK;
      6, 7:    cmd = CMD_SET_BULK;
      8:       cmd = $urandom_range(0, 1) ? CMD_READ : CMD_WRITE;
      default: cmd = $urandom_range(0, 1) ? CMD_UNKNOWN_A : CMD_UNKNOWN_B;
    endcase
    send_byte({cmd, 5'($urandom)});
    // READ and WRITE headers are swallowed, so they do not count as work.
    if (cmd != CMD_READ && cmd != CMD_WRITE) begin
      random_items++;
    end
    case (cmd)
      CMD_SET: begin
        send_byte(byte_t'($urandom));
        random_items++;
      end
      CMD_GET_BULK, CMD_SET_BULK: begin
        case ($urandom_range(0, 9))
          0:       len_byte = '0;
          9:       len_byte = byte_t'($urandom_range(CHANNELS + 1, 255));
          default: len_byte = byte_t'($urandom_range(1, CHANNELS));
        endcase
        send_byte(len_byte);
        random_items++;
        if (cmd == CMD_SET_BULK) begin
          data_count = (int'(len_byte) > CHANNELS) ? CHANNELS : int'(len_byte);
          repeat (data_count) begin
            send_byte(byte_t'($urandom));
            random_items++;
          end
        end
      end
      default: ;
    endcase
  endtask

  // Receiver side: for every reply it draws a number of stalled cycles, then
  // drops stall and waits for the transfer. Long bulk runs therefore see
  // stalls land on every byte position of the run.
  initial begin : reply_sink
    int hold;
    @(negedge clk);
    forever begin
      hold = steady ? 0 : $urandom_range(0, 8);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    rst          = 1'b1;
    in_valid     = 1'b0;
    rx_byte      = '0;
    out_stall    = 1'b0;
    steady       = 1'b0;
    random_items = 0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part. The row store starts cleared, so the first read is zero.
    send_byte(header(CMD_GET, 3'd0, 1'b0));
    // All-ones data on the top channel: bits above the row width are dropped.
    send_byte(header(CMD_SET, 3'd7, 1'b0));
    send_byte(8'hFF);
    send_byte(header(CMD_GET, 3'd7, 1'b0));
    // Two merged writes on one channel build up the value by OR.
    send_byte(header(CMD_SET, 3'd3, 1'b1));
    send_byte(8'h0A);
    send_byte(header(CMD_SET, 3'd3, 1'b1) | 8'h01);
    send_byte(8'hF5);
    send_byte(header(CMD_GET, 3'd3, 1'b0));
    // A bulk read of length zero gives nothing back.
    send_byte(header(CMD_GET_BULK, 3'd6, 1'b0));
    send_byte(8'h00);
    // The largest length is clamped to eight, and the run wraps past channel 7.
    send_byte(header(CMD_GET_BULK, 3'd5, 1'b0));
    send_byte(8'hFF);
    // A bulk write of length zero is acked at once.
    send_byte(header(CMD_SET_BULK, 3'd6, 1'b0));
    send_byte(8'h00);
    // A merged bulk write that wraps from channel 7 to channel 0.
    send_byte(header(CMD_SET_BULK, 3'd7, 1'b1));
    send_byte(8'h02);
    send_byte(8'hE1);
    send_byte(8'h02);
    // READ and WRITE are swallowed; the next byte is a header again.
    send_byte(header(CMD_READ, 3'd2, 1'b1));
    send_byte(header(CMD_WRITE, 3'd5, 1'b0) | 8'h01);
    // Both unknown commands, the second with every bit of the byte set.
    send_byte(header(CMD_UNKNOWN_A, 3'd1, 1'b0));
    send_byte(8'hFF);
    send_byte(header(CMD_GET, 3'd0, 1'b0));

    // Random part: mostly complete commands, with an occasional stray byte
    // that may leave the parser mid-command and desynchronize what follows.
    while (random_items < RANDOM_ITEMS) begin
      if ((random_items % 40) < 2) begin
        steady = ($urandom_range(0, 3) == 0);
      end
      if ($urandom_range(0, 9) == 0) begin
        send_byte(byte_t'($urandom));
        random_items++;
      end else begin
        send_random_command();
      end
    end
    in_valid <= 1'b0;
    steady = 1'b0;

    // Drain: wait for every predicted reply, then give the one-deep output
    // register time to show any stray transfer.
    while (expected_count != 0) @(negedge clk);
    repeat (16) @(negedge clk);
    if (fail_count == 0 && expected_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog. The timeout lies well beyond the slowest correct run, so it only
  // trips on a hang.
  initial begin : watchdog
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
